>>> rtl/clipped_shape_span_generator_defines.svh
// Assertion macros shared by the span generator RTL.
`ifndef CLIPPED_SHAPE_SPAN_GENERATOR_DEFINES_SVH
`define CLIPPED_SHAPE_SPAN_GENERATOR_DEFINES_SVH

// Checked on every clock edge outside reset.
`define CSG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked on every clock edge, reset included.
`define CSG_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/csg_pkg.sv
// Shared constants, register codes and beat types for the span generator.
`timescale 1ns / 1ps

package csg_pkg;

    // Field widths
    localparam int COORD_WIDTH = 16;
    localparam int EXT_W       = 12;
    localparam int COLOR_W     = 32;
    localparam int SCR_W       = 12;
    localparam int PITCH_W     = 13;
    localparam int OFS_W       = 24;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 2;

    // Square root datapath: one root bit per cell
    localparam int ROOT_W = EXT_W;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    // Signed working widths for row and column math
    localparam int SY_W  = COORD_WIDTH + 2;
    localparam int LEN_W = COORD_WIDTH + 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH    = 2'd2;

    // Register reset values
    localparam logic [SCR_W-1:0]   RST_SCREEN_WIDTH  = 12'd640;
    localparam logic [SCR_W-1:0]   RST_SCREEN_HEIGHT = 12'd480;
    localparam logic [PITCH_W-1:0] RST_LINE_PITCH    = 13'd640;

    typedef struct packed {
        logic [SCR_W-1:0]   scr_w;
        logic [SCR_W-1:0]   scr_h;
        logic [PITCH_W-1:0] pitch;
    } csg_cfg_t;

    // Data that rides along the root chain untouched
    typedef struct packed {
        logic                          circle;
        logic                          in_shape;
        logic signed [SY_W-1:0]        sy;
        logic signed [COORD_WIDTH-1:0] x;
        logic [EXT_W-1:0]              ea;
        logic [COLOR_W-1:0]            color;
    } csg_side_t;

    // Partial square root state
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } csg_sqrt_t;

    typedef struct packed {
        csg_side_t side;
        csg_sqrt_t sq;
    } csg_beat_t;

    // Clipped span before the offset multiply
    typedef struct packed {
        logic                   visible;
        logic [SCR_W-1:0]       sy;
        logic [COORD_WIDTH-1:0] xofs;
        logic [SCR_W-1:0]       len;
        logic [COLOR_W-1:0]     color;
    } csg_span_t;

endpackage

>>> rtl/csg_front.sv
// Input stage: shape test, screen row and square root radicand.
`timescale 1ns / 1ps

module csg_front
    import csg_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          cmd,
    input  logic signed [COORD_WIDTH-1:0] x_pos,
    input  logic signed [COORD_WIDTH-1:0] y_pos,
    input  logic [EXT_W-1:0]              extent_a,
    input  logic [EXT_W-1:0]              extent_b,
    input  logic [EXT_W-1:0]              row_index,
    input  logic [COLOR_W-1:0]            fill_color,
    output logic                          out_valid,
    input  logic                          out_ready,
    output csg_beat_t                     out_beat
);

    localparam int PROD_W = 2 * EXT_W + 1;

    logic [EXT_W:0]          ea_x2;
    logic [EXT_W:0]          i_ext;
    logic [EXT_W:0]          chord_w;
    logic [PROD_W-1:0]       prod;
    logic                    inside_circ;
    logic                    inside_rect;
    logic signed [SY_W-1:0]  y_ext;
    logic signed [SY_W-1:0]  ea_s;
    logic signed [SY_W-1:0]  i_s;
    logic signed [SY_W-1:0]  sy;
    logic                    vld_reg;
    csg_beat_t               beat_reg;
    csg_beat_t               beat_next;

    // Shape membership
    assign ea_x2       = {extent_a, 1'b0};
    assign i_ext       = {1'b0, row_index};
    assign inside_circ = i_ext < ea_x2;
    assign inside_rect = row_index < extent_b;

    // Screen row of this shape row
    assign y_ext = {{(SY_W-COORD_WIDTH){y_pos[COORD_WIDTH-1]}}, y_pos};
    assign ea_s  = {{(SY_W-EXT_W){1'b0}}, extent_a};
    assign i_s   = {{(SY_W-EXT_W){1'b0}}, row_index};
    assign sy    = cmd ? (y_ext - ea_s + i_s) : (y_ext + i_s);

    // r^2 - (r-i)^2 = i * (2r - i), zero on row 0 and positive below it inside the circle
    assign chord_w = ea_x2 - i_ext;
    assign prod    = PROD_W'(row_index) * PROD_W'(chord_w);

    always_comb begin
        beat_next.side.circle   = cmd;
        beat_next.side.in_shape = cmd ? inside_circ : inside_rect;
        beat_next.side.sy       = sy;
        beat_next.side.x        = x_pos;
        beat_next.side.ea       = extent_a;
        beat_next.side.color    = fill_color;
        beat_next.sq.rad        = (cmd && inside_circ) ? prod[RAD_W-1:0] : '0;
        beat_next.sq.rem        = '0;
        beat_next.sq.root       = '0;
    end

    // Pipeline register
    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_beat  = beat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            beat_reg <= beat_next;
        end
    end

endmodule

>>> rtl/csg_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per beat.
`timescale 1ns / 1ps

module csg_sqrt_cell
    import csg_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  csg_beat_t in_beat,
    output logic      out_valid,
    input  logic      out_ready,
    output csg_beat_t out_beat
);

    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             take;
    logic             vld_reg;
    csg_beat_t        beat_reg;
    csg_beat_t        beat_next;

    // Bring down the next two radicand bits and try root*4+1
    assign rem_sh = {in_beat.sq.rem, in_beat.sq.rad[RAD_W-1 -: 2]};
    assign trial  = {2'b00, in_beat.sq.root, 2'b01};
    assign diff   = rem_sh - trial;
    assign take   = rem_sh >= trial;

    always_comb begin
        beat_next         = in_beat;
        beat_next.sq.rad  = {in_beat.sq.rad[RAD_W-3:0], 2'b00};
        beat_next.sq.rem  = take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        beat_next.sq.root = {in_beat.sq.root[ROOT_W-2:0], take};
    end

    // Pipeline register
    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_beat  = beat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            beat_reg <= beat_next;
        end
    end

endmodule

>>> rtl/csg_back.sv
// Output stages: visibility, left and right clipping, frame buffer offset.
`timescale 1ns / 1ps

module csg_back
    import csg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  csg_cfg_t           cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  csg_beat_t          in_beat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               row_visible,
    output logic [OFS_W-1:0]   row_offset,
    output logic [SCR_W-1:0]   span_length,
    output logic [COLOR_W-1:0] span_color
);

    localparam int MUL_W = SCR_W + PITCH_W + 1;

    logic signed [LEN_W-1:0] x_ext;
    logic signed [LEN_W-1:0] half_ext;
    logic signed [LEN_W-1:0] ea_ext;
    logic signed [LEN_W-1:0] w_ext;
    logic signed [LEN_W-1:0] len0;
    logic signed [LEN_W-1:0] xofs0;
    logic signed [LEN_W-1:0] len1;
    logic signed [LEN_W-1:0] xofs1;
    logic signed [LEN_W-1:0] len2;
    logic [SY_W-2:0]         sy_mag;
    logic [SY_W-2:0]         h_ext;
    logic                    visible;
    logic [MUL_W-1:0]        ofs_full;
    logic                    a_ready;
    logic                    a_vld_reg;
    csg_span_t               a_reg;
    csg_span_t               a_next;
    logic                    out_vld_reg;
    logic                    vis_reg;
    logic [OFS_W-1:0]        ofs_reg;
    logic [SCR_W-1:0]        len_reg;
    logic [COLOR_W-1:0]      color_reg;

    // Raw span from the shape
    assign x_ext    = {{(LEN_W-COORD_WIDTH){in_beat.side.x[COORD_WIDTH-1]}}, in_beat.side.x};
    assign half_ext = {{(LEN_W-ROOT_W){1'b0}}, in_beat.sq.root};
    assign ea_ext   = {{(LEN_W-EXT_W){1'b0}}, in_beat.side.ea};
    assign w_ext    = {{(LEN_W-SCR_W){1'b0}}, cfg.scr_w};
    assign len0     = in_beat.side.circle ? (half_ext <<< 1) : ea_ext;
    assign xofs0    = in_beat.side.circle ? (x_ext - half_ext) : x_ext;

    // Vertical test
    assign sy_mag  = in_beat.side.sy[SY_W-2:0];
    assign h_ext   = (SY_W-1)'(cfg.scr_h);
    assign visible = in_beat.side.in_shape && !in_beat.side.sy[SY_W-1] && (sy_mag < h_ext);

    // Left clip, right clip, clamp at zero
    always_comb begin
        if (xofs0 < 0) begin
            len1  = len0 + xofs0;
            xofs1 = '0;
        end else begin
            len1  = len0;
            xofs1 = xofs0;
        end
        if (xofs1 + len1 >= w_ext) begin
            len2 = w_ext - xofs1;
        end else begin
            len2 = len1;
        end
        a_next.visible = visible;
        a_next.sy      = sy_mag[SCR_W-1:0];
        a_next.xofs    = xofs1[COORD_WIDTH-1:0];
        a_next.len     = (len2 < 0) ? '0 : len2[SCR_W-1:0];
        a_next.color   = in_beat.side.color;
    end

    // Clip stage register
    assign a_ready  = !out_vld_reg || out_ready;
    assign in_ready = !a_vld_reg || a_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (in_ready) begin
            a_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            a_reg <= a_next;
        end
    end

    // Row start times pitch plus clipped x
    assign ofs_full = MUL_W'(a_reg.sy) * MUL_W'(cfg.pitch) + MUL_W'(a_reg.xofs);

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (a_ready) begin
            out_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && a_vld_reg) begin
            vis_reg   <= a_reg.visible;
            ofs_reg   <= a_reg.visible ? ofs_full[OFS_W-1:0] : '0;
            len_reg   <= a_reg.visible ? a_reg.len : '0;
            color_reg <= a_reg.color;
        end
    end

    assign out_valid   = out_vld_reg;
    assign row_visible = vis_reg;
    assign row_offset  = ofs_reg;
    assign span_length = len_reg;
    assign span_color  = color_reg;

endmodule

>>> rtl/clipped_shape_span_generator.sv
// Clipped shape span generator: top level with register file and cell chain.
//
// Each input beat (s_*) asks for one row of a filled rectangle (s_cmd 0) or a
// filled circle (s_cmd 1). Each output beat (m_*) carries the clipped span of
// that row: frame buffer offset of the first pixel, length and fill color, or
// row_visible low with zero offset and length when the row is off the shape
// or above or below the screen. Results leave in the order the requests came in.
// The user must write screen width, screen height and line pitch through the
// cfg_* port only while no request is in flight; the block does not enforce
// this. They take effect on the next beat. The pipeline has one input stage,
// twelve square root cells (one root bit each) and two output stages for
// clipping and the offset multiply. One beat is accepted per cycle when the
// output side keeps up. When m_ready is low, stages fill one by one; s_ready
// drops only once all fifteen stages hold a beat. Reset empties the pipeline
// and loads the registers with 640 x 480 and a pitch of 640.
`timescale 1ns / 1ps
`include "clipped_shape_span_generator_defines.svh"

module clipped_shape_span_generator
    import csg_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    // Register write port
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    // Request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  logic signed [COORD_WIDTH-1:0] s_x_pos,
    input  logic signed [COORD_WIDTH-1:0] s_y_pos,
    input  logic [EXT_W-1:0]              s_extent_a,
    input  logic [EXT_W-1:0]              s_extent_b,
    input  logic [EXT_W-1:0]              s_row_index,
    input  logic [COLOR_W-1:0]            s_fill_color,
    // Span channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_row_visible,
    output logic [OFS_W-1:0]              m_row_offset,
    output logic [SCR_W-1:0]              m_span_length,
    output logic [COLOR_W-1:0]            m_span_color
);

    csg_cfg_t    cfg_reg;
    logic        chain_vld [ROOT_W+1];
    logic        chain_rdy [ROOT_W+1];
    csg_beat_t   chain_beat [ROOT_W+1];

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scr_w <= RST_SCREEN_WIDTH;
            cfg_reg.scr_h <= RST_SCREEN_HEIGHT;
            cfg_reg.pitch <= RST_LINE_PITCH;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SCREEN_WIDTH: begin
                    cfg_reg.scr_w <= cfg_data[SCR_W-1:0];
                end
                REG_SCREEN_HEIGHT: begin
                    cfg_reg.scr_h <= cfg_data[SCR_W-1:0];
                end
                REG_LINE_PITCH: begin
                    cfg_reg.pitch <= cfg_data[PITCH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input stage
    csg_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .cmd        (s_cmd),
        .x_pos      (s_x_pos),
        .y_pos      (s_y_pos),
        .extent_a   (s_extent_a),
        .extent_b   (s_extent_b),
        .row_index  (s_row_index),
        .fill_color (s_fill_color),
        .out_valid  (chain_vld[0]),
        .out_ready  (chain_rdy[0]),
        .out_beat   (chain_beat[0])
    );

    // Square root chain, most significant root bit first
    for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
        csg_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_vld[k]),
            .in_ready  (chain_rdy[k]),
            .in_beat   (chain_beat[k]),
            .out_valid (chain_vld[k+1]),
            .out_ready (chain_rdy[k+1]),
            .out_beat  (chain_beat[k+1])
        );
    end

    // Clipping and offset
    csg_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (chain_vld[ROOT_W]),
        .in_ready    (chain_rdy[ROOT_W]),
        .in_beat     (chain_beat[ROOT_W]),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .row_visible (m_row_visible),
        .row_offset  (m_row_offset),
        .span_length (m_span_length),
        .span_color  (m_span_color)
    );

    // Checks
    `CSG_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid, "output valid right after reset")
    `CSG_ASSERT(a_stall_only_full, !s_ready |-> m_valid, "input stalled with output empty")
    `CSG_ASSERT(a_hidden_zero, (m_valid && !m_row_visible) |-> (m_row_offset == '0 && m_span_length == '0), "hidden row carries a span")
    `CSG_ASSERT(a_len_needs_vis, (m_valid && m_span_length != '0) |-> m_row_visible, "nonzero length on hidden row")

endmodule
